@@ hw/rtl/ffp_pkg.sv @@
// Shared constants and types for the free frame pool.
`timescale 1ns / 1ps

package ffp_pkg;

    localparam int POOL_DEPTH_DEF = 4096;
    localparam int FRAME_BITS_DEF = 20;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic CFG_FIRST_FRAME = 1'b0;
    localparam logic CFG_LAST_FRAME  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ hw/rtl/free_frame_pool.sv @@
// Free frame pool top level: request decode, counters, result buffering.
`timescale 1ns / 1ps

// Hands out physical frame numbers oldest first. After reset the pool holds the
// range first_frame..last_frame (clamped to POOL_DEPTH frames), issued through a
// counter; freed frames queue behind them in a POOL_DEPTH-entry store, so no
// fill or clearing pass is needed. Each request gives one result. Free requests,
// allocations from the fresh range, and empty or full rejections go straight to the
// result buffer; an allocation from the store waits on its registered read, and no new
// request is taken meanwhile. A two-deep result buffer lets a new request enter while
// a finished result waits on the output. Write first_frame/last_frame only idle.
module free_frame_pool
    import ffp_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    localparam int IN_BITS   = ((FRAME_BITS + 7) / 8) * 8,
    localparam int LEFT_BITS = $clog2(POOL_DEPTH + 1),
    localparam int OUT_BITS  = ((FRAME_BITS + LEFT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [FRAME_BITS-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_BITS-1:0]    s_axis_tdata,   // frame
    input  logic                  s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_BITS-1:0]   m_axis_tdata,   // granted_frame, frames_left
    output logic [1:0]            m_axis_tuser    // status
);

    localparam int IDX_BITS  = $clog2(POOL_DEPTH);
    localparam int DIFF_BITS = (FRAME_BITS > LEFT_BITS) ? FRAME_BITS : LEFT_BITS;
    localparam int SUM_BITS  = LEFT_BITS + 1;

    logic [FRAME_BITS-1:0] r_first;
    logic [FRAME_BITS-1:0] r_last;
    logic [LEFT_BITS-1:0]  r_range;
    logic [LEFT_BITS-1:0]  r_fresh_taken;
    logic [IDX_BITS-1:0]   r_head;
    logic [IDX_BITS-1:0]   r_tail;
    logic [LEFT_BITS-1:0]  r_queue_count;
    logic                  r_rd_pend;
    logic                  r_hold_valid;
    logic                  r_hold_mem;
    logic [FRAME_BITS-1:0] r_hold_frame;
    t_status               r_hold_status;
    logic [LEFT_BITS-1:0]  r_hold_left;
    logic                  r_out_valid;
    logic [FRAME_BITS-1:0] r_out_frame;
    t_status               r_out_status;
    logic [LEFT_BITS-1:0]  r_out_left;

    logic [FRAME_BITS-1:0] n_first;
    logic [FRAME_BITS-1:0] n_last;
    logic [DIFF_BITS-1:0]  w_diff;
    logic [LEFT_BITS-1:0]  n_range;
    logic [LEFT_BITS-1:0]  w_fresh;
    logic [SUM_BITS-1:0]   w_sum;
    logic                  w_accept;
    logic                  w_mode;
    logic [FRAME_BITS-1:0] w_frame;
    logic                  w_take_fresh;
    logic                  w_take_queue;
    logic                  w_push;
    t_status               w_status;
    logic [FRAME_BITS-1:0] w_granted;
    logic [SUM_BITS-1:0]   w_left_after;
    logic                  w_hold_move;
    logic [FRAME_BITS-1:0] w_rd_data;
    logic [FRAME_BITS-1:0] w_hold_frame;
    logic [IDX_BITS-1:0]   w_head_nx;
    logic [IDX_BITS-1:0]   w_tail_nx;

    // Range size is kept registered, computed from the incoming register values on a write.
    always_comb begin
        n_first = (i_cfg_we && i_cfg_addr == CFG_FIRST_FRAME) ? i_cfg_wdata : r_first;
        n_last  = (i_cfg_we && i_cfg_addr == CFG_LAST_FRAME) ? i_cfg_wdata : r_last;
        w_diff  = DIFF_BITS'(n_last) - DIFF_BITS'(n_first);
        if (n_last < n_first) begin
            n_range = '0;
        end else if (w_diff >= DIFF_BITS'(POOL_DEPTH - 1)) begin
            n_range = LEFT_BITS'(POOL_DEPTH);
        end else begin
            n_range = LEFT_BITS'(w_diff + DIFF_BITS'(1));
        end
    end

    always_comb begin
        w_fresh  = (r_fresh_taken >= r_range) ? '0 : (r_range - r_fresh_taken);
        w_sum    = SUM_BITS'(w_fresh) + SUM_BITS'(r_queue_count);
        w_mode   = s_axis_tuser;
        w_frame  = s_axis_tdata[FRAME_BITS-1:0];
        w_accept = s_axis_tvalid && s_axis_tready;

        w_take_fresh = (w_mode == MODE_ALLOC) && (w_fresh != '0);
        w_take_queue = (w_mode == MODE_ALLOC) && (w_fresh == '0) && (r_queue_count != '0);
        w_push       = (w_mode == MODE_FREE) && (w_sum < SUM_BITS'(POOL_DEPTH));

        w_granted = FRAME_BITS'(DIFF_BITS'(r_first) + DIFF_BITS'(r_fresh_taken));

        priority if (w_take_fresh || w_take_queue) begin
            w_status     = ST_OK;
            w_left_after = w_sum - SUM_BITS'(1);
        end else if (w_push) begin
            w_status     = ST_OK;
            w_left_after = w_sum + SUM_BITS'(1);
        end else if (w_mode == MODE_ALLOC) begin
            w_status     = ST_EMPTY;
            w_left_after = w_sum;
        end else begin
            w_status     = ST_FULL;
            w_left_after = w_sum;
        end

        w_head_nx = (r_head == IDX_BITS'(POOL_DEPTH - 1)) ? '0 : r_head + IDX_BITS'(1);
        w_tail_nx = (r_tail == IDX_BITS'(POOL_DEPTH - 1)) ? '0 : r_tail + IDX_BITS'(1);

        w_hold_move  = r_hold_valid && (!r_out_valid || m_axis_tready);
        w_hold_frame = r_hold_mem ? w_rd_data : r_hold_frame;
    end

    assign s_axis_tready = !r_rd_pend && (!r_hold_valid || !r_out_valid || m_axis_tready);

    ffp_store #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (FRAME_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_push),
        .i_wr_addr (r_tail),
        .i_wr_data (w_frame),
        .i_rd_en   (w_accept && w_take_queue),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first       <= '0;
            r_last        <= '0;
            r_range       <= '0;
            r_fresh_taken <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_queue_count <= '0;
            r_rd_pend     <= 1'b0;
            r_hold_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_first <= n_first;
            r_last  <= n_last;
            r_range <= n_range;

            if (w_accept) begin
                if (w_take_fresh) begin
                    r_fresh_taken <= r_fresh_taken + LEFT_BITS'(1);
                end
                if (w_take_queue) begin
                    r_head        <= w_head_nx;
                    r_queue_count <= r_queue_count - LEFT_BITS'(1);
                end
                if (w_push) begin
                    r_tail        <= w_tail_nx;
                    r_queue_count <= r_queue_count + LEFT_BITS'(1);
                end
            end

            if (w_hold_move) begin
                r_hold_valid <= 1'b0;
            end
            r_rd_pend <= w_accept && w_take_queue;
            if (r_rd_pend || (w_accept && !w_take_queue)) begin
                r_hold_valid <= 1'b1;
            end

            if (w_hold_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_mem    <= w_take_queue;
            r_hold_frame  <= w_take_fresh ? w_granted : '0;
            r_hold_status <= w_status;
            r_hold_left   <= LEFT_BITS'(w_left_after);
        end
        if (w_hold_move) begin
            r_out_frame  <= w_hold_frame;
            r_out_status <= r_hold_status;
            r_out_left   <= r_hold_left;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_BITS'({r_out_left, r_out_frame});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queue_count <= LEFT_BITS'(POOL_DEPTH))
        else $error("queue count beyond pool depth");

    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (!s_axis_tready && !r_hold_valid))
        else $error("request taken during store read");

    a_read_fills_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_hold_valid)
        else $error("store read result lost");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status != ST_OK) |=>
            ($stable(r_fresh_taken) && $stable(r_queue_count)
             && $stable(r_head) && $stable(r_tail)))
        else $error("rejected request changed pool state");

    a_hold_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_valid && !w_hold_move) |=> r_hold_valid)
        else $error("buffered result dropped");
`endif

endmodule

@@ hw/rtl/ffp_store.sv @@
// Freed-frame store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ffp_store
    import ffp_pkg::*;
#(
    parameter int DEPTH = POOL_DEPTH_DEF,
    parameter int WIDTH = FRAME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/free_frame_pool_test.sv @@
// Self-checking testbench for the free frame pool: directed and random requests.
`timescale 1ns / 1ps

module free_frame_pool_test;
    import ffp_pkg::*;

    localparam int DEPTH = POOL_DEPTH_DEF;
    localparam int FB    = FRAME_BITS_DEF;
    localparam int LB    = $clog2(DEPTH + 1);
    localparam int IN_W  = ((FB + 7) / 8) * 8;
    localparam int OUT_W = ((FB + LB + 7) / 8) * 8;
    localparam logic [FB-1:0] FRAME_MAX = '1;

    typedef struct packed {
        logic [FB-1:0] frame;
        t_status       status;
        logic [LB-1:0] left;
    } t_grant;

    class pool_scoreboard;
        logic [FB-1:0] first_frame;
        logic [FB-1:0] last_frame;
        int unsigned   fresh_taken;
        int unsigned   head;
        int unsigned   tail;
        int unsigned   queued;
        logic [FB-1:0] freed [DEPTH];
        t_grant        pending[$];
        int            errors;

        function new();
            first_frame = '0;
            last_frame  = '0;
            fresh_taken = 0;
            head        = 0;
            tail        = 0;
            queued      = 0;
            errors      = 0;
        endfunction

        function void configure(logic idx, logic [FB-1:0] value);
            if (idx == CFG_FIRST_FRAME) first_frame = value;
            else last_frame = value;
        endfunction

        function int unsigned fresh_count();
            int unsigned span;
            if (last_frame < first_frame) return 0;
            span = int'(last_frame) - int'(first_frame) + 1;
            if (span > DEPTH) span = DEPTH;
            return (fresh_taken >= span) ? 0 : span - fresh_taken;
        endfunction

        function void note_request(logic mode, logic [FB-1:0] frame);
            t_grant      g;
            int unsigned fresh;
            fresh    = fresh_count();
            g.frame  = '0;
            g.status = ST_OK;
            if (mode == MODE_ALLOC) begin
                if (fresh > 0) begin
                    g.frame = first_frame + FB'(fresh_taken);
                    fresh_taken++;
                    fresh--;
                end else if (queued > 0) begin
                    g.frame = freed[head];
                    head    = (head + 1) % DEPTH;
                    queued--;
                end else begin
                    g.status = ST_EMPTY;
                end
            end else begin
                if (fresh + queued >= DEPTH) begin
                    g.status = ST_FULL;
                end else begin
                    freed[tail] = frame;
                    tail        = (tail + 1) % DEPTH;
                    queued++;
                end
            end
            g.left = LB'(fresh + queued);
            pending.push_back(g);
        endfunction

        function void check_result(logic [FB-1:0] frame, t_status status,
                                   logic [LB-1:0] left);
            t_grant g;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, got frame %h status %0d left %0d",
                         $time, frame, status, left);
                errors++;
                return;
            end
            g = pending.pop_front();
            if (frame !== g.frame) begin
                $display("%0t: granted_frame expected %h, got %h", $time, g.frame, frame);
                errors++;
            end
            if (status !== g.status) begin
                $display("%0t: status expected %0d, got %0d", $time, g.status, status);
                errors++;
            end
            if (left !== g.left) begin
                $display("%0t: frames_left expected %0d, got %0d", $time, g.left, left);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_addr;
    logic [FB-1:0]     i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // frame
    logic              s_axis_tuser;   // mode
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // granted_frame, frames_left
    logic [1:0]        m_axis_tuser;   // status

    pool_scoreboard sb = new();
    bit calm;
    bit hold_off;

    free_frame_pool dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    always begin
        @(negedge i_clk);
        if (hold_off) begin
            m_axis_tready <= 1'b0;
            repeat (80) @(negedge i_clk);
            hold_off = 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end else begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[FB-1:0], t_status'(m_axis_tuser),
                            m_axis_tdata[FB+LB-1:FB]);
    end

    task automatic push(input logic mode, input logic [FB-1:0] frame);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= IN_W'(frame);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(mode, frame);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FB-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(idx, value);
    endtask

    task automatic set_range(input logic [FB-1:0] lo, input logic [FB-1:0] hi);
        settle();
        write_reg(CFG_FIRST_FRAME, lo);
        write_reg(CFG_LAST_FRAME, hi);
    endtask

    function automatic logic [FB-1:0] pick_frame();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FRAME_MAX;
            default: return FB'($urandom);
        endcase
    endfunction

    // kind: 0 empty range, 1 clamped, 2 short, 3 top frame only, 4 frame zero only
    task automatic random_range(input int kind);
        logic [FB-1:0] lo;
        logic [FB-1:0] hi;
        case (kind)
            0: begin
                lo = FB'($urandom_range(1, int'(FRAME_MAX)));
                hi = FB'($urandom_range(0, int'(lo) - 1));
            end
            1: begin
                lo = FB'($urandom_range(0, 1000));
                hi = (FB'($urandom_range(0, 1)) == 0) ? FRAME_MAX : lo + FB'(DEPTH + 50);
            end
            2: begin
                lo = FB'($urandom_range(0, int'(FRAME_MAX) - 64));
                hi = lo + FB'($urandom_range(0, 60));
            end
            3: begin
                lo = FRAME_MAX;
                hi = FRAME_MAX;
            end
            default: begin
                lo = '0;
                hi = '0;
            end
        endcase
        set_range(lo, hi);
    endtask

    task automatic run_phase(input int count, input int free_pct, input bit mid_pause,
                             input bit mid_hold);
        for (int k = 0; k < count; k++) begin
            if (mid_pause && k == count / 2) settle();
            if (mid_hold && k == count / 3) hold_off = 1'b1;
            push(($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC, pick_frame());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_FIRST_FRAME;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ALLOC;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        hold_off      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset range holds frame 0 only; then empty pool and requeue order
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, FRAME_MAX);
        push(MODE_FREE, FRAME_MAX);
        push(MODE_FREE, '0);
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, '0);

        // empty range
        set_range(FB'(5), FB'(3));
        push(MODE_ALLOC, '0);
        push(MODE_FREE, FB'('hAAAAA));
        push(MODE_FREE, FB'('h55555));
        push(MODE_ALLOC, FRAME_MAX);
        push(MODE_ALLOC, '0);

        // clamped full range: pool reaches full, free rejected
        set_range('0, FRAME_MAX);
        push(MODE_FREE, pick_frame());
        push(MODE_FREE, pick_frame());
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, '0);

        // range moved to the top after frames were taken
        set_range(FRAME_MAX - FB'(15), FRAME_MAX);
        push(MODE_ALLOC, '0);

        // range shrunk below the taken count: store only
        set_range(FRAME_MAX, FRAME_MAX);
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, '0);
        push(MODE_ALLOC, '0);

        random_range(2); run_phase(175, 30, 1'b0, 1'b0);
        random_range(1); run_phase(175, 75, 1'b0, 1'b1);
        random_range(1); run_phase(175, 25, 1'b0, 1'b0);
        random_range(0); run_phase(175, 20, 1'b1, 1'b0);
        random_range(2); run_phase(175, 60, 1'b0, 1'b0);
        random_range(1); run_phase(175, 50, 1'b0, 1'b0);
        random_range(3); run_phase(175, 40, 1'b0, 1'b0);
        random_range(4);
        calm = 1'b1;
        run_phase(175, 50, 1'b0, 1'b0);

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ffp_pkg.sv
hw/rtl/ffp_store.sv
hw/rtl/free_frame_pool.sv
tb/free_frame_pool_test.sv
